[rtl/core/swtm_pkg.sv]
// Shared constants, widths and codes for the sliding-window trimmed mean.
// Used by the interfaces, the serial divider and the top level.
package swtm_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int SAMPLE_BITS  = 16;
  localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS     = ADDR_BITS + 1;
  localparam int SUM_BITS     = SAMPLE_BITS + ADDR_BITS;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

  // Configuration register widths and indexes.
  localparam int WLEN_BITS    = 9;
  localparam int TRIM_BITS    = 7;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 9;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIM_COUNT    = 2'd1;

  // Result status codes.
  localparam int STATUS_BITS = 2;
  localparam logic [STATUS_BITS-1:0] STATUS_FILLING = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_VALID   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD_CFG = 2'd2;

endpackage

[rtl/core/swtm_if.sv]
// Valid/ready channel interfaces for samples and results.
// Depends on swtm_pkg for the payload widths.
interface swtm_in_if;
  logic                               valid;
  logic                               ready;
  logic [swtm_pkg::SAMPLE_BITS-1:0]   sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swtm_out_if;
  logic                               valid;
  logic                               ready;
  logic [swtm_pkg::STATUS_BITS-1:0]   status;
  logic [swtm_pkg::SAMPLE_BITS-1:0]   mk_average;
  modport source (output valid, output status, output mk_average, input ready);
  modport sink   (input valid, input status, input mk_average, output ready);
endinterface

[rtl/core/swtm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/swtm_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on swtm_pkg for the dividend and divisor widths.
module swtm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [swtm_pkg::SUM_BITS-1:0]  dividend,
  input  logic [swtm_pkg::CNT_BITS-1:0]  divisor,
  output logic                           done,
  output logic [swtm_pkg::SUM_BITS-1:0]  quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [swtm_pkg::DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [swtm_pkg::SUM_BITS-1:0]     quo_r, quo_nxt;
  logic [swtm_pkg::CNT_BITS-1:0]     rem_r, rem_nxt;
  logic [swtm_pkg::CNT_BITS-1:0]     div_r, div_nxt;
  logic [swtm_pkg::CNT_BITS:0]       rem_sh;
  logic                              fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh   = {rem_r, quo_r[swtm_pkg::SUM_BITS-1]};
    fits     = rem_sh >= {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[swtm_pkg::SUM_BITS-2:0], fits};
      if (fits) begin
        rem_nxt = swtm_pkg::CNT_BITS'(rem_sh - {1'b0, div_r});
      end else begin
        rem_nxt = rem_sh[swtm_pkg::CNT_BITS-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == swtm_pkg::DIV_CNT_BITS'(swtm_pkg::SUM_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/sliding_window_trimmed_mean.sv]
// Sliding-window trimmed mean: arrival ring and sorted store in two RAMs.
// Each accepted sample runs through removal of the oldest sample (once the window is full),
// insertion shifts into the sorted store and, for a valid average, a sum of the middle
// samples and the serial divider. A new sample is accepted only once the previous result
// has been placed in the output register.
// Reset: window_length = 256, trim_count = 0, window empty; RAM contents not cleared.
module sliding_window_trimmed_mean (
  input  logic                               clk,
  input  logic                               rst_n,
  swtm_in_if.sink                            in_ch,
  swtm_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [swtm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [swtm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AB = swtm_pkg::ADDR_BITS;
  localparam int CB = swtm_pkg::CNT_BITS;
  localparam int SB = swtm_pkg::SAMPLE_BITS;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_OLD     = 4'd1;
  localparam logic [3:0] ST_SCAN    = 4'd2;
  localparam logic [3:0] ST_SHIFT   = 4'd3;
  localparam logic [3:0] ST_INS_RD  = 4'd4;
  localparam logic [3:0] ST_INS_CMP = 4'd5;
  localparam logic [3:0] ST_INS_PUT = 4'd6;
  localparam logic [3:0] ST_EVAL    = 4'd7;
  localparam logic [3:0] ST_SUM     = 4'd8;
  localparam logic [3:0] ST_DIV     = 4'd9;
  localparam logic [3:0] ST_DONE    = 4'd10;

  logic [3:0]                          state_r, state_nxt;
  logic [swtm_pkg::WLEN_BITS-1:0]      wlen_r, wlen_nxt;
  logic [swtm_pkg::TRIM_BITS-1:0]      trim_r, trim_nxt;
  logic [AB-1:0]                       ptr_r, ptr_nxt;
  logic [CB-1:0]                       fill_r, fill_nxt;
  logic [CB-1:0]                       len_r, len_nxt;
  logic [CB-1:0]                       idx_r, idx_nxt;
  logic [SB-1:0]                       samp_r, samp_nxt;
  logic [SB-1:0]                       old_r, old_nxt;
  logic [swtm_pkg::SUM_BITS-1:0]       sum_r, sum_nxt;
  logic [swtm_pkg::STATUS_BITS-1:0]    res_status_r, res_status_nxt;
  logic [SB-1:0]                       res_avg_r, res_avg_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [swtm_pkg::STATUS_BITS-1:0]    out_status_r, out_status_nxt;
  logic [SB-1:0]                       out_avg_r, out_avg_nxt;

  logic [CB-1:0]                       held_len;
  logic                                cfg_bad;
  logic [CB-1:0]                       mid_end;
  logic [CB-1:0]                       mid_cnt;
  logic [CB-1:0]                       ptr_inc;

  logic          a_we;
  logic [AB-1:0] a_waddr, a_raddr;
  logic [SB-1:0] a_wdata, a_rdata;
  logic          s_we;
  logic [AB-1:0] s_waddr, s_raddr;
  logic [SB-1:0] s_wdata, s_rdata;

  logic                          div_start;
  logic                          div_done;
  logic [swtm_pkg::SUM_BITS-1:0] div_quo;

  // Window length actually held, and the configuration check.
  always_comb begin
    if (wlen_r == '0) begin
      held_len = CB'(1);
    end else if (32'(wlen_r) > swtm_pkg::WINDOW_DEPTH) begin
      held_len = CB'(swtm_pkg::WINDOW_DEPTH);
    end else begin
      held_len = CB'(wlen_r);
    end
    cfg_bad = (wlen_r == '0) || (32'(wlen_r) > swtm_pkg::WINDOW_DEPTH) ||
              ({2'b0, trim_r, 1'b0} >= {1'b0, wlen_r});
    mid_end = len_r - CB'(trim_r);
    mid_cnt = len_r - CB'({trim_r, 1'b0});
    ptr_inc = CB'(ptr_r) + 1'b1;
  end

  // Sequencer over the two memories.
  always_comb begin
    state_nxt      = state_r;
    wlen_nxt       = wlen_r;
    trim_nxt       = trim_r;
    ptr_nxt        = ptr_r;
    fill_nxt       = fill_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    samp_nxt       = samp_r;
    old_nxt        = old_r;
    sum_nxt        = sum_r;
    res_status_nxt = res_status_r;
    res_avg_nxt    = res_avg_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_avg_nxt    = out_avg_r;
    a_we           = 1'b0;
    a_waddr        = ptr_r;
    a_wdata        = samp_r;
    a_raddr        = ptr_r;
    s_we           = 1'b0;
    s_waddr        = idx_r[AB-1:0];
    s_wdata        = samp_r;
    s_raddr        = '0;
    div_start      = 1'b0;

    // A transfer on the result channel frees the output register.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Writes to the window length or trim count registers empty the window.
    if (cfg_we) begin
      if (cfg_index == swtm_pkg::CFG_WINDOW_LENGTH) begin
        wlen_nxt = cfg_data[swtm_pkg::WLEN_BITS-1:0];
        ptr_nxt  = '0;
        fill_nxt = '0;
      end else if (cfg_index == swtm_pkg::CFG_TRIM_COUNT) begin
        trim_nxt = cfg_data[swtm_pkg::TRIM_BITS-1:0];
        ptr_nxt  = '0;
        fill_nxt = '0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          samp_nxt = in_ch.sample;
          len_nxt  = held_len;
          if (fill_r >= held_len) begin
            state_nxt = ST_OLD;
          end else begin
            state_nxt = ST_INS_RD;
          end
        end
      end
      ST_OLD: begin
        old_nxt   = a_rdata;
        idx_nxt   = '0;
        s_raddr   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (s_rdata == old_r) begin
          if (idx_r + 1'b1 < fill_r) begin
            s_raddr   = AB'(idx_r + 1'b1);
            state_nxt = ST_SHIFT;
          end else begin
            fill_nxt  = fill_r - 1'b1;
            state_nxt = ST_INS_RD;
          end
        end else if (idx_r + 1'b1 < fill_r) begin
          idx_nxt = idx_r + 1'b1;
          s_raddr = AB'(idx_r + 1'b1);
        end else begin
          state_nxt = ST_INS_RD;
        end
      end
      ST_SHIFT: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + CB'(2) < fill_r) begin
          s_raddr = AB'(idx_r + CB'(2));
        end else begin
          fill_nxt  = fill_r - 1'b1;
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        a_we    = 1'b1;
        idx_nxt = fill_r;
        if (fill_r != '0) begin
          s_raddr   = AB'(fill_r - 1'b1);
          state_nxt = ST_INS_CMP;
        end else begin
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_CMP: begin
        if (s_rdata > samp_r) begin
          s_we    = 1'b1;
          s_wdata = s_rdata;
          idx_nxt = idx_r - 1'b1;
          if (idx_r > CB'(1)) begin
            s_raddr = AB'(idx_r - CB'(2));
          end else begin
            state_nxt = ST_INS_PUT;
          end
        end else begin
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        s_we     = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (ptr_inc == len_r) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_inc[AB-1:0];
        end
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        res_avg_nxt = '0;
        if (cfg_bad) begin
          res_status_nxt = swtm_pkg::STATUS_BAD_CFG;
          state_nxt      = ST_DONE;
        end else if (fill_r < len_r) begin
          res_status_nxt = swtm_pkg::STATUS_FILLING;
          state_nxt      = ST_DONE;
        end else begin
          idx_nxt   = CB'(trim_r);
          sum_nxt   = '0;
          s_raddr   = AB'(trim_r);
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt = sum_r + swtm_pkg::SUM_BITS'(s_rdata);
        if (idx_r + 1'b1 < mid_end) begin
          idx_nxt = idx_r + 1'b1;
          s_raddr = AB'(idx_r + 1'b1);
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = (sum_nxt != sum_r) || 1'b0;
        if (div_done) begin
          res_status_nxt = swtm_pkg::STATUS_VALID;
          res_avg_nxt    = div_quo[SB-1:0];
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_avg_nxt    = res_avg_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The divider starts on the cycle the sum is complete.
    if (state_r == ST_SUM && !(idx_r + 1'b1 < mid_end)) begin
      div_start = 1'b1;
    end
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wlen_r      <= swtm_pkg::WLEN_BITS'(swtm_pkg::WINDOW_DEPTH);
      trim_r      <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wlen_r      <= wlen_nxt;
      trim_r      <= trim_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r        <= len_nxt;
    idx_r        <= idx_nxt;
    samp_r       <= samp_nxt;
    old_r        <= old_nxt;
    sum_r        <= sum_nxt;
    res_status_r <= res_status_nxt;
    res_avg_r    <= res_avg_nxt;
    out_status_r <= out_status_nxt;
    out_avg_r    <= out_avg_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.mk_average = out_avg_r;

  // Samples in arrival order.
  swtm_ram #(.WIDTH(SB), .DEPTH(swtm_pkg::WINDOW_DEPTH)) u_arrival (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Window samples in ascending order.
  swtm_ram #(.WIDTH(SB), .DEPTH(swtm_pkg::WINDOW_DEPTH)) u_sorted (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Serial division of the middle sum by the middle count.
  swtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (mid_cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

[verif/tb_sliding_window_trimmed_mean.sv]
// Self-checking testbench for the sliding-window trimmed mean block.
// Depends on swtm_pkg, the swtm_in_if/swtm_out_if interfaces and the block itself;
// results are predicted by a windowed sort model held in this module.
`timescale 1ns / 1ps

module tb_sliding_window_trimmed_mean;

  typedef struct packed {
    logic [swtm_pkg::STATUS_BITS-1:0] status;
    logic [swtm_pkg::SAMPLE_BITS-1:0] mk_average;
  } mean_result_t;

  localparam int TOTAL_SAMPLES = 1600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [swtm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [swtm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  swtm_in_if  in_ch ();
  swtm_out_if out_ch ();

  sliding_window_trimmed_mean i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Window model state and its configuration copy.
  logic [swtm_pkg::WLEN_BITS-1:0]   win_len = swtm_pkg::WLEN_BITS'(swtm_pkg::WINDOW_DEPTH);
  logic [swtm_pkg::TRIM_BITS-1:0]   trim_cnt = '0;
  logic [swtm_pkg::SAMPLE_BITS-1:0] ring_mem [swtm_pkg::WINDOW_DEPTH];
  logic [swtm_pkg::SAMPLE_BITS-1:0] sorted_mem [swtm_pkg::WINDOW_DEPTH];
  int                               ring_ptr = 0;
  int                               held_cnt = 0;

  logic [swtm_pkg::SAMPLE_BITS-1:0] sample_q [$];
  mean_result_t                     mean_q [$];
  int                               src_idle_pct = 0;
  int                               snk_idle_pct = 0;
  int                               samples_queued = 0;
  int                               errors = 0;
  bit                               hold_req = 1'b0;
  logic                             hold_active = 1'b0;

  // Update the window with one sample and queue the expected result.
  function automatic void predict_mean(input logic [swtm_pkg::SAMPLE_BITS-1:0] s);
    int len;
    int idx;
    int i;
    int mid_cnt;
    logic [swtm_pkg::SUM_BITS-1:0] mid_sum;
    mean_result_t res;
    len = (win_len == 0) ? 1 : ((win_len > swtm_pkg::WINDOW_DEPTH) ?
          swtm_pkg::WINDOW_DEPTH : int'(win_len));
    idx = ring_ptr;
    if (held_cnt >= len) begin
      i = 0;
      while (i < held_cnt && sorted_mem[i] != ring_mem[idx]) i++;
      if (i < held_cnt) begin
        for (; i + 1 < held_cnt; i++) sorted_mem[i] = sorted_mem[i+1];
        held_cnt--;
      end
    end
    ring_mem[idx] = s;
    i = held_cnt;
    while (i > 0 && sorted_mem[i-1] > s) begin
      sorted_mem[i] = sorted_mem[i-1];
      i--;
    end
    sorted_mem[i] = s;
    held_cnt++;
    ring_ptr = (idx + 1) % len;
    res.mk_average = '0;
    if (win_len == 0 || win_len > swtm_pkg::WINDOW_DEPTH ||
        2 * int'(trim_cnt) >= int'(win_len)) begin
      res.status = swtm_pkg::STATUS_BAD_CFG;
    end else if (held_cnt < len) begin
      res.status = swtm_pkg::STATUS_FILLING;
    end else begin
      mid_sum = '0;
      for (i = trim_cnt; i < len - trim_cnt; i++) mid_sum += sorted_mem[i];
      mid_cnt = len - 2 * trim_cnt;
      res.status = swtm_pkg::STATUS_VALID;
      res.mk_average = swtm_pkg::SAMPLE_BITS'(mid_sum / mid_cnt);
    end
    mean_q.push_back(res);
  endfunction

  // Sender: offers queued samples, predicting each one when its transfer completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_mean(in_ch.sample);
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.sample <= sample_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (mean_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result: status %0d average %0d",
                                     out_ch.status, out_ch.mk_average);
        end else begin
          mean_result_t exp_res;
          exp_res = mean_q.pop_front();
          if (out_ch.status !== exp_res.status || out_ch.mk_average !== exp_res.mk_average)
          begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected status %0d average %0d, got status %0d average %0d",
                       exp_res.status, exp_res.mk_average, out_ch.status, out_ch.mk_average);
          end
        end
      end
      out_ch.ready <= !hold_active && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (1500) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic write_reg(input logic [swtm_pkg::CFG_IDX_BITS-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= swtm_pkg::CFG_DATA_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == swtm_pkg::CFG_WINDOW_LENGTH) win_len = swtm_pkg::WLEN_BITS'(value);
    if (idx == swtm_pkg::CFG_TRIM_COUNT) trim_cnt = swtm_pkg::TRIM_BITS'(value);
    if (idx == swtm_pkg::CFG_WINDOW_LENGTH || idx == swtm_pkg::CFG_TRIM_COUNT) begin
      ring_ptr = 0;
      held_cnt = 0;
    end
  endtask

  task automatic set_window(input int len, input int trim);
    if ($urandom_range(1)) begin
      write_reg(swtm_pkg::CFG_WINDOW_LENGTH, len);
      write_reg(swtm_pkg::CFG_TRIM_COUNT, trim);
    end else begin
      write_reg(swtm_pkg::CFG_TRIM_COUNT, trim);
      write_reg(swtm_pkg::CFG_WINDOW_LENGTH, len);
    end
  endtask

  // Wait until every sample has been transferred and every result checked.
  task automatic drain();
    while (sample_q.size() > 0 || in_ch.valid || mean_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_sample(input logic [swtm_pkg::SAMPLE_BITS-1:0] s);
    sample_q.push_back(s);
    samples_queued++;
    src_idle_pct = (samples_queued < TOTAL_SAMPLES / 3) ? 20 :
                   (samples_queued < 2 * TOTAL_SAMPLES / 3) ? 88 : 0;
    snk_idle_pct = (samples_queued < TOTAL_SAMPLES / 3) ? 88 :
                   (samples_queued < 2 * TOTAL_SAMPLES / 3) ? 20 : 0;
  endtask

  function automatic logic [swtm_pkg::SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(3))
      0: rand_sample = swtm_pkg::SAMPLE_BITS'($urandom);
      1: rand_sample = $urandom_range(1) ? '1 : '0;
      2: rand_sample = swtm_pkg::SAMPLE_BITS'($urandom_range(7));
      default: rand_sample = swtm_pkg::SAMPLE_BITS'(65535 - $urandom_range(15));
    endcase
  endfunction

  initial begin
    int len;
    int trim;
    int count;
    int phase;
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a few samples at reset settings, then edge windows and bad settings.
    queue_sample('0);
    queue_sample('1);
    queue_sample(16'h1234);
    drain();
    set_window(1, 0);
    queue_sample('1);
    queue_sample('0);
    queue_sample(16'h8000);
    drain();
    set_window(3, 1);
    queue_sample('1); queue_sample('0); queue_sample('1); queue_sample(16'h7FFF);
    queue_sample('0); queue_sample('0);
    drain();
    // Writes to unused register indexes must leave the window untouched.
    write_reg(2'd2, 9'h1FF);
    write_reg(2'd3, 0);
    queue_sample(16'h0001); queue_sample('1);
    drain();
    set_window(0, 0);
    queue_sample(16'h00FF); queue_sample(16'hFF00);
    drain();
    set_window(300, 3);
    queue_sample(16'h5555); queue_sample(16'hAAAA);
    drain();
    set_window(4, 2);
    queue_sample('1); queue_sample('0);
    drain();
    set_window(511, 127);
    queue_sample(16'h0F0F);
    drain();

    // Largest window with the deepest legal trim.
    set_window(swtm_pkg::WINDOW_DEPTH, 127);
    for (i = 0; i < swtm_pkg::WINDOW_DEPTH + 20; i++) queue_sample(rand_sample());
    drain();

    // Random settings, mostly small windows so that each result is quick.
    phase = 0;
    while (samples_queued < TOTAL_SAMPLES) begin
      case ($urandom_range(9))
        0, 1: begin
          len = $urandom_range(0, 511);
          trim = $urandom_range(0, 127);
        end
        2: begin
          len = $urandom_range(13, 64);
          trim = $urandom_range(0, (len - 1) / 2);
        end
        default: begin
          len = $urandom_range(1, 12);
          trim = $urandom_range(0, (len - 1) / 2);
        end
      endcase
      set_window(len, trim);
      count = ((len >= 1 && len <= 64) ? len : 4) + $urandom_range(5, 40);
      for (i = 0; i < count; i++) begin
        if (phase == 3 && i == count / 2) drain();
        queue_sample(rand_sample());
      end
      if (phase == 5) hold_req = 1'b1;
      drain();
      phase++;
    end

    drain();
    if (mean_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
